// File: hw/rtl/cpwc_pkg.sv
// package for the contact pair watch counter
// widths, codes and packed word types shared by the interfaces, cpwc_match and the top module
`default_nettype none

package cpwc_pkg;

   localparam int ENTRIES    = 64;
   localparam int ID_BITS    = 16;
   localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_BITS   = $clog2(ENTRIES + 1);
   localparam int OP_BITS    = 3;
   localparam int COUNT_BITS = 8;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef enum logic [OP_BITS-1:0] {
      OP_ADD_SINGLE   = 3'd0,
      OP_ADD_PAIR     = 3'd1,
      OP_CONTACT_BEG  = 3'd2,
      OP_CONTACT_END  = 3'd3,
      OP_READ_COUNT   = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_FULL       = 2'd1,
      ST_NOT_IN_USE = 2'd2
   } status_type;

   typedef struct packed {
      logic [ID_BITS-1:0]    first_id;
      logic [ID_BITS-1:0]    second_id;
      logic [COUNT_BITS-1:0] count;
   } entry_type;

   typedef struct packed {
      logic                  hit;
      logic [COUNT_BITS-1:0] count;
   } match_type;

   typedef struct packed {
      logic [IDX_BITS-1:0]   assigned_index;
      logic [COUNT_BITS-1:0] count_value;
      logic [CNT_BITS-1:0]   matched_entries;
      status_type            status;
   } rsp_word_type;

endpackage

`default_nettype wire

// File: hw/rtl/cpwc_req_if.sv
// request channel of the contact pair watch counter
// valid/ready handshake with the op word; depends on cpwc_pkg
`default_nettype none

interface cpwc_req_if;
   import cpwc_pkg::*;

   logic                valid;
   logic                ready;
   logic [OP_BITS-1:0]  opcode;
   logic [ID_BITS-1:0]  first_id;
   logic [ID_BITS-1:0]  second_id;
   logic [IDX_BITS-1:0] entry_index;

   modport source (output valid, output opcode, output first_id, output second_id,
                   output entry_index, input ready);
   modport sink (input valid, input opcode, input first_id, input second_id,
                 input entry_index, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/cpwc_rsp_if.sv
// response channel of the contact pair watch counter
// valid/ready handshake with the result word; depends on cpwc_pkg
`default_nettype none

interface cpwc_rsp_if;
   import cpwc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [IDX_BITS-1:0]   assigned_index;
   logic [COUNT_BITS-1:0] count_value;
   logic [CNT_BITS-1:0]   matched_entries;
   logic [1:0]            status;

   modport source (output valid, output assigned_index, output count_value,
                   output matched_entries, output status, input ready);
   modport sink (input valid, input assigned_index, input count_value,
                 input matched_entries, input status, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/cpwc_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module cpwc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/cpwc_match.sv
// match test and saturating counter update for one watch entry
// depends on cpwc_pkg
`default_nettype none

module cpwc_match (
   input  cpwc_pkg::entry_type                 entry,
   input  logic [cpwc_pkg::ID_BITS-1:0]        first_id,
   input  logic [cpwc_pkg::ID_BITS-1:0]        second_id,
   input  logic                                count_up,
   output cpwc_pkg::match_type                 result
);
   import cpwc_pkg::*;

   logic single_hit;
   logic pair_hit;

   assign single_hit = (first_id == entry.first_id) || (second_id == entry.first_id);
   assign pair_hit   = ((first_id == entry.first_id) && (second_id == entry.second_id)) ||
                       ((first_id == entry.second_id) && (second_id == entry.first_id));

   always_comb begin
      // an entry with both slots equal watches a single body
      if (entry.first_id == entry.second_id) begin
         result.hit = single_hit;
      end else begin
         result.hit = pair_hit;
      end

      if (count_up) begin
         result.count = (entry.count == COUNT_MAX) ? entry.count : entry.count + 1'b1;
      end else begin
         result.count = (entry.count == '0) ? entry.count : entry.count - 1'b1;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/contact_pair_watch_counter.sv
// Contact pair watch counter. Entries (one body id, or a pair of ids) are added in order
// and each keeps an 8-bit contact counter that saturates at 0 and 255; a contact begin or
// end word scans every entry in use and bumps each match, and a read count word returns one
// counter. All entries live in one memory with a registered read, so a contact event
// steps through the entries in use at one entry per cycle (the memory has a single read
// port), a read count passes through S_READ, and adds and unused opcodes go straight to
// S_DONE. One word is worked on at a time; a finished result sits in an output register,
// so the next word is accepted while it waits to be taken. No clearing pass follows reset.
// Depends on cpwc_pkg, cpwc_req_if, cpwc_rsp_if, cpwc_ram and cpwc_match.
`default_nettype none

module contact_pair_watch_counter (
   input  logic       clock,
   input  logic       reset,
   cpwc_req_if.sink   req_ch,
   cpwc_rsp_if.source rsp_ch
);
   import cpwc_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_READ = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_BITS-1:0] used_ff, used_in;
   logic [IDX_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ID_BITS-1:0]  first_ff, first_in;
   logic [ID_BITS-1:0]  second_ff, second_in;
   logic                count_up_ff, count_up_in;
   rsp_word_type        res_ff, res_in;
   rsp_word_type        out_ff, out_in;
   logic                out_valid_ff, out_valid_in;

   logic                ram_wr_en;
   logic [IDX_BITS-1:0] ram_wr_addr;
   entry_type           ram_wr_data;
   logic                ram_rd_en;
   logic [IDX_BITS-1:0] ram_rd_addr;
   entry_type           ram_rd_data;
   match_type           match_res;

   cpwc_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   cpwc_match u_match (
      .entry     (ram_rd_data),
      .first_id  (first_ff),
      .second_id (second_ff),
      .count_up  (count_up_ff),
      .result    (match_res)
   );

   assign req_ch.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      rd_ptr_in    = rd_ptr_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      count_up_in  = count_up_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = rd_ptr_ff;
      ram_wr_data  = ram_rd_data;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = rd_ptr_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               res_in      = '0;
               first_in    = req_ch.first_id;
               second_in   = req_ch.second_id;
               count_up_in = (op_type'(req_ch.opcode) == OP_CONTACT_BEG);
               state_in    = S_DONE;
               case (op_type'(req_ch.opcode))
                  OP_ADD_SINGLE, OP_ADD_PAIR: begin
                     if (used_ff == CNT_BITS'(ENTRIES)) begin
                        res_in.status = ST_FULL;
                     end else begin
                        ram_wr_en             = 1'b1;
                        ram_wr_addr           = IDX_BITS'(used_ff);
                        ram_wr_data.first_id  = req_ch.first_id;
                        ram_wr_data.second_id = (op_type'(req_ch.opcode) == OP_ADD_PAIR) ?
                                                req_ch.second_id : req_ch.first_id;
                        ram_wr_data.count     = '0;
                        used_in               = used_ff + 1'b1;
                        res_in.assigned_index = IDX_BITS'(used_ff);
                     end
                  end
                  OP_CONTACT_BEG, OP_CONTACT_END: begin
                     if (used_ff != '0) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = '0;
                        rd_ptr_in   = '0;
                        state_in    = S_SCAN;
                     end
                  end
                  OP_READ_COUNT: begin
                     if (CNT_BITS'(req_ch.entry_index) < used_ff) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = req_ch.entry_index;
                        state_in    = S_READ;
                     end else begin
                        res_in.status = ST_NOT_IN_USE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            // data for rd_ptr_ff arrives now; write back and fetch the next entry together
            if (match_res.hit) begin
               ram_wr_en              = 1'b1;
               ram_wr_addr            = rd_ptr_ff;
               ram_wr_data.count      = match_res.count;
               res_in.matched_entries = res_ff.matched_entries + 1'b1;
            end
            if (CNT_BITS'(rd_ptr_ff) + 1'b1 == used_ff) begin
               state_in = S_DONE;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = rd_ptr_ff + 1'b1;
               rd_ptr_in   = rd_ptr_ff + 1'b1;
            end
         end
         S_READ: begin
            res_in.count_value = ram_rd_data.count;
            state_in           = S_DONE;
         end
         S_DONE: begin
            if (!out_valid_ff || rsp_ch.ready) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff   <= rd_ptr_in;
      first_ff    <= first_in;
      second_ff   <= second_in;
      count_up_ff <= count_up_in;
      res_ff      <= res_in;
      out_ff      <= out_in;
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.assigned_index  = out_ff.assigned_index;
   assign rsp_ch.count_value     = out_ff.count_value;
   assign rsp_ch.matched_entries = out_ff.matched_entries;
   assign rsp_ch.status          = out_ff.status;

   a_used_bounded: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_BITS'(ENTRIES))
      else $error("entry count beyond table size");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> CNT_BITS'(rd_ptr_ff) < used_ff)
      else $error("scan pointer past entries in use");

   a_matched_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> res_ff.matched_entries < used_ff + 1'b1)
      else $error("match count exceeds entries scanned");

   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en && ram_rd_en |-> ram_wr_addr != ram_rd_addr)
      else $error("entry ram read and write hit the same entry");

endmodule

`default_nettype wire

// File: test/contact_pair_watch_counter_tb.sv
// testbench for contact_pair_watch_counter: directed and random words on the request channel,
// results checked in order against a scoreboard that tracks the watch table
// depends on cpwc_pkg, cpwc_req_if, cpwc_rsp_if and the rtl of the block
`timescale 1ns / 100ps

module contact_pair_watch_counter_tb;
   import cpwc_pkg::*;

   localparam int HOLD_CYCLES  = 400;
   localparam int IDLE_LIMIT   = 4000;
   localparam int TAIL_CYCLES  = ENTRIES + 8;
   localparam int REPORT_LIMIT = 10;
   localparam logic [OP_BITS-1:0] OP_FIRST_UNUSED = OP_BITS'(OP_READ_COUNT + 1);
   localparam logic [OP_BITS-1:0] OP_LAST_UNUSED  = '1;
   localparam logic [ID_BITS-1:0] ID_MAX = '1;

   class watch_table_board;
      logic [ID_BITS-1:0]    body_a [ENTRIES];
      logic [ID_BITS-1:0]    body_b [ENTRIES];
      logic [COUNT_BITS-1:0] tally [ENTRIES];
      int                    used;
      rsp_word_type          expected_results [$];
      int                    errors, checked, words_seen;
      int                    full_answers, capped, floored, peak_matched;

      function new();
         used = 0;
         errors = 0;
         checked = 0;
         words_seen = 0;
         full_answers = 0;
         capped = 0;
         floored = 0;
         peak_matched = 0;
      endfunction

      function void predict_word(logic [OP_BITS-1:0] opc, logic [ID_BITS-1:0] a,
                                 logic [ID_BITS-1:0] b, logic [IDX_BITS-1:0] ix);
         rsp_word_type want;
         int           hits;
         int           i;
         logic         hit;
         want = '0;
         hits = 0;
         words_seen++;
         case (opc)
            OP_ADD_SINGLE, OP_ADD_PAIR: begin
               if (used == ENTRIES) begin
                  want.status = ST_FULL;
                  full_answers++;
               end else begin
                  body_a[used] = a;
                  body_b[used] = (opc == OP_ADD_SINGLE) ? a : b;
                  tally[used] = '0;
                  want.assigned_index = IDX_BITS'(used);
                  used++;
               end
            end
            OP_CONTACT_BEG, OP_CONTACT_END: begin
               for (i = 0; i < used; i++) begin
                  // equal slots make a single-id entry, hit by either body
                  if (body_a[i] == body_b[i])
                     hit = (a == body_a[i]) || (b == body_a[i]);
                  else
                     hit = (a == body_a[i] && b == body_b[i]) ||
                           (a == body_b[i] && b == body_a[i]);
                  if (hit) begin
                     hits++;
                     if (opc == OP_CONTACT_BEG) begin
                        if (tally[i] == COUNT_MAX) capped++;
                        else tally[i]++;
                     end else begin
                        if (tally[i] == '0) floored++;
                        else tally[i]--;
                     end
                  end
               end
               want.matched_entries = CNT_BITS'(hits);
               if (hits > peak_matched) peak_matched = hits;
            end
            OP_READ_COUNT: begin
               if (ix < used) want.count_value = tally[ix];
               else want.status = ST_NOT_IN_USE;
            end
            default: ;
         endcase
         expected_results.insert(expected_results.size(), want);
      endfunction

      function void check_result(rsp_word_type got);
         rsp_word_type want;
         if (expected_results.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("%0t: unexpected result: index %0d count %0d matched %0d status %0d",
                        $time, got.assigned_index, got.count_value, got.matched_entries,
                        got.status);
            return;
         end
         want = expected_results.pop_front();
         checked++;
         if (got.assigned_index !== want.assigned_index || got.count_value !== want.count_value
             || got.matched_entries !== want.matched_entries || got.status !== want.status) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("%0t: mismatch: expected index %0d count %0d matched %0d status %0d, %s",
                        $time, want.assigned_index, want.count_value, want.matched_entries,
                        want.status, $sformatf("got index %0d count %0d matched %0d status %0d",
                        got.assigned_index, got.count_value, got.matched_entries, got.status));
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   cpwc_req_if req_ch ();
   cpwc_rsp_if rsp_ch ();

   contact_pair_watch_counter dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   watch_table_board   board = new();
   logic [ID_BITS-1:0] hot_ids [8];
   bit                 quiet = 1'b0;
   bit                 hold_off_req = 1'b0;

   always #5 clock = ~clock;

   // mostly short gaps, a few long ones
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [ID_BITS-1:0] pick_id(int span);
      if ($urandom_range(0, 99) < 85) return hot_ids[$urandom_range(0, span - 1)];
      return ID_BITS'($urandom);
   endfunction

   task automatic send_word(input logic [OP_BITS-1:0] opc, input logic [ID_BITS-1:0] a,
                            input logic [ID_BITS-1:0] b, input logic [IDX_BITS-1:0] ix);
      int gap;
      gap = quiet ? 0 : gap_len();
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.opcode = opc;
      req_ch.first_id = a;
      req_ch.second_id = b;
      req_ch.entry_index = ix;
      req_ch.valid = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // stop offering words and wait until every result is back
   task automatic settle();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (board.expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic run_phase(input int words, input int w_add, input int w_beg, input int w_end,
                            input int w_read, input int span);
      logic [OP_BITS-1:0]  opc;
      logic [IDX_BITS-1:0] ix;
      int                  r;
      int                  n;
      for (n = 0; n < words; n++) begin
         r = $urandom_range(0, 99);
         if (r < w_add) opc = $urandom_range(0, 1) ? OP_ADD_PAIR : OP_ADD_SINGLE;
         else if (r < w_add + w_beg) opc = OP_CONTACT_BEG;
         else if (r < w_add + w_beg + w_end) opc = OP_CONTACT_END;
         else if (r < w_add + w_beg + w_end + w_read) opc = OP_READ_COUNT;
         else opc = OP_BITS'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
         if (board.used > 0 && $urandom_range(0, 3) != 0)
            ix = IDX_BITS'($urandom_range(0, board.used - 1));
         else
            ix = IDX_BITS'($urandom_range(0, ENTRIES - 1));
         send_word(opc, pick_id(span), pick_id(span), ix);
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type seen;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.assigned_index = rsp_ch.assigned_index;
            seen.count_value = rsp_ch.count_value;
            seen.matched_entries = rsp_ch.matched_entries;
            seen.status = status_type'(rsp_ch.status);
            board.check_result(seen);
         end
         if (req_ch.valid && req_ch.ready)
            board.predict_word(req_ch.opcode, req_ch.first_id, req_ch.second_id,
                               req_ch.entry_index);
      end
   end

   // result side: alternating ready runs and stalls, plus a long hold-off on request
   initial begin
      int phase_left;
      int hold_left;
      phase_left = 0;
      hold_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
         end else if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ch.ready = 1'b0;
            hold_left = HOLD_CYCLES;
         end else if (phase_left > 0) begin
            phase_left--;
         end else begin
            rsp_ch.ready = ~rsp_ch.ready;
            if (rsp_ch.ready)
               phase_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                          : $urandom_range(0, 40);
            else
               phase_left = gap_len();
         end
      end
   end

   initial begin
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle = 0;
         else
            idle++;
      end
      $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("contact_pair_watch_counter_tb: FAIL");
      $finish;
   end

   initial begin
      int k;
      req_ch.valid = 1'b0;
      req_ch.opcode = OP_ADD_SINGLE;
      req_ch.first_id = '0;
      req_ch.second_id = '0;
      req_ch.entry_index = '0;
      hot_ids[0] = ID_MAX;
      hot_ids[1] = '0;
      hot_ids[2] = 16'h1234;
      hot_ids[3] = 16'h5555;
      for (k = 4; k < 8; k++) hot_ids[k] = ID_BITS'($urandom);
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // empty table: reads miss, contacts match nothing
      send_word(OP_READ_COUNT, '0, '0, '0);
      send_word(OP_CONTACT_BEG, '0, ID_MAX, '0);
      send_word(OP_ADD_SINGLE, ID_MAX, 16'h00aa, '0);
      send_word(OP_ADD_PAIR, 16'h0000, 16'h1234, '0);
      send_word(OP_ADD_PAIR, 16'h1234, 16'h0000, '0);
      // pair added with equal ids behaves as a single-id entry
      send_word(OP_ADD_PAIR, 16'h5555, 16'h5555, '0);
      // decrement at zero stays at zero
      send_word(OP_CONTACT_END, ID_MAX, 16'h0042, '0);
      send_word(OP_CONTACT_BEG, 16'h0042, ID_MAX, '0);
      send_word(OP_CONTACT_BEG, 16'h1234, 16'h0000, '0);
      send_word(OP_CONTACT_BEG, 16'h0000, 16'h1234, '0);
      // one body of a pair twice is no match
      send_word(OP_CONTACT_BEG, 16'h0000, 16'h0000, '0);
      send_word(OP_CONTACT_BEG, 16'h5555, 16'h5555, '0);
      send_word(OP_CONTACT_END, 16'h1234, 16'h9999, '0);
      send_word(OP_READ_COUNT, ID_MAX, ID_MAX, 6'd0);
      send_word(OP_READ_COUNT, '0, '0, 6'd1);
      send_word(OP_READ_COUNT, '0, '0, 6'd3);
      send_word(OP_READ_COUNT, '0, '0, 6'd4);
      send_word(OP_READ_COUNT, '0, '0, '1);
      send_word(OP_FIRST_UNUSED, ID_MAX, ID_MAX, '1);
      send_word(OP_FIRST_UNUSED + 1'b1, 16'haaaa, 16'h5555, 6'h2a);
      send_word(OP_LAST_UNUSED, ID_MAX, ID_MAX, '1);
      send_word(OP_CONTACT_END, 16'h0000, 16'h1234, '0);
      send_word(OP_ADD_SINGLE, 16'h8000, 16'h7fff, '0);
      settle();

      // fill the table and run past full
      run_phase(300, 35, 25, 15, 20, 8);
      settle();

      // drive counters into the top limit on two hot ids, result side held off first
      hold_off_req = 1'b1;
      quiet = 1'b1;
      run_phase(80, 3, 90, 2, 4, 2);
      quiet = 1'b0;
      run_phase(320, 3, 90, 2, 4, 2);
      settle();

      // and back down through zero
      run_phase(380, 2, 3, 85, 8, 2);
      settle();

      hold_off_req = 1'b1;
      run_phase(200, 15, 30, 30, 20, 8);
      settle();

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d words: %0d table-full answers, %0d increments held at 255, %s",
               board.words_seen, board.full_answers, board.capped,
               $sformatf("%0d decrements held at 0", board.floored));
      $display("largest contact match %0d entries; %0d results checked, %0d mismatches",
               board.peak_matched, board.checked, board.errors);
      if (board.errors == 0 && board.expected_results.size() == 0)
         $display("contact_pair_watch_counter_tb: PASS");
      else
         $display("contact_pair_watch_counter_tb: FAIL");
      $finish;
   end

endmodule

// File: contact_pair_watch_counter.f
hw/rtl/cpwc_pkg.sv
hw/rtl/cpwc_req_if.sv
hw/rtl/cpwc_rsp_if.sv
hw/rtl/cpwc_ram.sv
hw/rtl/cpwc_match.sv
hw/rtl/contact_pair_watch_counter.sv
test/contact_pair_watch_counter_tb.sv
